// ----- design/c2dz_pkg.sv -----
// Shared constants and types for the same-size 2-D convolution unit.
`default_nettype none

package c2dz_pkg;

    // Default size limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_KERNEL = 5;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int POS_W   = 3;
    localparam int OUT_W   = 29;
    localparam int IMG_W   = 11;
    localparam int KSZ_W   = 3;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register reset values
    localparam logic [IMG_W-1:0] RST_IMG_W = 11'd1024;
    localparam logic [IMG_W-1:0] RST_IMG_H = 11'd1024;
    localparam logic [KSZ_W-1:0] RST_KER_W = 3'd3;
    localparam logic [KSZ_W-1:0] RST_KER_H = 3'd3;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_IMG_W = 2'd0;
    localparam logic [1:0] REG_IMG_H = 2'd1;
    localparam logic [1:0] REG_KER_W = 2'd2;
    localparam logic [1:0] REG_KER_H = 2'd3;

    // Item kinds carried in tuser
    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_DRAIN = 2'd1,
        OP_COEF  = 2'd2
    } t_op;

endpackage

`default_nettype wire

// ----- design/conv2d_same_zero_pad_unit.sv -----
// Same-size 2-D convolution with zero padding: line memories, window and MAC pipeline.
//
// Usage:
//   s_* input stream: tuser holds the item kind (pixel, drain, coefficient load),
//   tdata the pixel and the coefficient fields. Load the kernel with coefficient
//   beats, then stream pixels in raster order, then drain beats until the beat
//   flagged tlast appears on the m_* output stream. m_tdata holds the signed
//   Q.12 sum of one output pixel, m_tlast marks the last pixel of the frame.
//   The APB port sets image and kernel size; write it only while idle.
//   The result of an input beat is registered in stage 1, stage 2, stage 3 and
//   the output register. Throughput: one beat per cycle when the output does
//   not stall, set by the single read port of each line memory, read once per
//   pixel beat, written back as stage 1 advances, with same-column forwarding.
//   Output pixel k appears for input beat k + (kernel_height/2)*width
//   + kernel_width/2; earlier beats give no result.
//   Reset clears the stream position, the window and the pipeline valids and
//   restores the register defaults; kernel and line memories are not cleared.
//   When the receiver stalls, the pipeline holds and fills its empty stages,
//   so input beats keep flowing until every stage holds an item.
`default_nettype none

module conv2d_same_zero_pad_unit #(
    parameter int MAX_WIDTH  = c2dz_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c2dz_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = c2dz_pkg::DEF_MAX_KERNEL
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // pixel[7:0], coef_row[10:8], coef_col[13:11],
                                       // coef_value[29:14], zero[31:30]
    input  wire logic [1:0]  s_tuser,  // op[1:0]
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // conv_value[28:0], zero[31:29]
    output logic             m_tlast,  // last_of_frame
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [c2dz_pkg::PADDR_W-1:0] paddr,
    input  wire logic [c2dz_pkg::PDATA_W-1:0] pwdata,
    output logic      [c2dz_pkg::PDATA_W-1:0] prdata,
    output logic             pready
);

    localparam int MK  = MAX_KERNEL;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int KW  = $clog2(MK + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int DW  = $clog2((MK / 2) * MAX_WIDTH + MK / 2 + 2);
    localparam int PW  = c2dz_pkg::PIX_W + 1 + c2dz_pkg::COEF_W;
    localparam int SW  = PW + $clog2(MK * MK + 1);
    localparam int PXW = c2dz_pkg::PIX_W;

    // ---------------- configuration ----------------
    logic [c2dz_pkg::IMG_W-1:0] r_img_w, r_img_h;
    logic [c2dz_pkg::KSZ_W-1:0] r_ker_w, r_ker_h;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= c2dz_pkg::RST_IMG_W;
            r_img_h <= c2dz_pkg::RST_IMG_H;
            r_ker_w <= c2dz_pkg::RST_KER_W;
            r_ker_h <= c2dz_pkg::RST_KER_H;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                c2dz_pkg::REG_IMG_W: r_img_w <= pwdata[c2dz_pkg::IMG_W-1:0];
                c2dz_pkg::REG_IMG_H: r_img_h <= pwdata[c2dz_pkg::IMG_W-1:0];
                c2dz_pkg::REG_KER_W: r_ker_w <= pwdata[c2dz_pkg::KSZ_W-1:0];
                c2dz_pkg::REG_KER_H: r_ker_h <= pwdata[c2dz_pkg::KSZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr[3:2])
            c2dz_pkg::REG_IMG_W: prdata = c2dz_pkg::PDATA_W'(r_img_w);
            c2dz_pkg::REG_IMG_H: prdata = c2dz_pkg::PDATA_W'(r_img_h);
            c2dz_pkg::REG_KER_W: prdata = c2dz_pkg::PDATA_W'(r_ker_w);
            c2dz_pkg::REG_KER_H: prdata = c2dz_pkg::PDATA_W'(r_ker_h);
            default:             prdata = '0;
        endcase
    end

    // Clamp sizes into their legal ranges
    logic [WW-1:0] w_c;
    logic [HW-1:0] h_c;
    logic [KW-1:0] kw_c, kh_c, cx, cy;
    logic [DW-1:0] delay;

    always_comb begin
        if (r_img_w == '0)                 w_c = WW'(1);
        else if (32'(r_img_w) > MAX_WIDTH) w_c = WW'(MAX_WIDTH);
        else                               w_c = WW'(r_img_w);
        if (r_img_h == '0)                  h_c = HW'(1);
        else if (32'(r_img_h) > MAX_HEIGHT) h_c = HW'(MAX_HEIGHT);
        else                                h_c = HW'(r_img_h);
        if (r_ker_w == '0)          kw_c = KW'(1);
        else if (32'(r_ker_w) > MK) kw_c = KW'(MK);
        else                        kw_c = KW'(r_ker_w);
        if (r_ker_h == '0)          kh_c = KW'(1);
        else if (32'(r_ker_h) > MK) kh_c = KW'(MK);
        else                        kh_c = KW'(r_ker_h);
        cx    = kw_c >> 1;
        cy    = kh_c >> 1;
        delay = DW'(int'(cy) * int'(w_c) + int'(cx));
    end

    // ---------------- handshake and pipeline control ----------------
    logic r_v1, r_v2, r_v3, r_ov;
    logic adv1, adv2, adv3, adv_o;
    logic acc, pix_acc, coef_acc;
    c2dz_pkg::t_op op;

    assign adv_o    = !r_ov || m_tready;
    assign adv3     = !r_v3 || adv_o;
    assign adv2     = !r_v2 || adv3;
    assign adv1     = !r_v1 || adv2;
    assign s_tready = adv1;
    assign acc      = s_tvalid && s_tready;
    assign op       = c2dz_pkg::t_op'(s_tuser);

    always_comb begin
        pix_acc  = 1'b0;
        coef_acc = 1'b0;
        case (op)
            c2dz_pkg::OP_PIXEL, c2dz_pkg::OP_DRAIN: pix_acc  = acc;
            c2dz_pkg::OP_COEF:                      coef_acc = acc;
            default: ;
        endcase
    end

    // ---------------- kernel store ----------------
    logic signed [c2dz_pkg::COEF_W-1:0] r_coef [MK][MK];
    logic [c2dz_pkg::POS_W-1:0] in_row, in_col;

    assign in_row = s_tdata[10:8];
    assign in_col = s_tdata[13:11];

    // Write one coefficient; drop positions outside the kernel
    always_ff @(posedge i_clk) begin
        for (int m = 0; m < MK; m++) begin
            for (int n = 0; n < MK; n++) begin
                if (coef_acc && int'(in_row) == m && int'(in_col) == n) begin
                    r_coef[m][n] <= s_tdata[29:14];
                end
            end
        end
    end

    // ---------------- stream position ----------------
    logic [DW-1:0] r_cnt;
    logic          r_run;
    logic [CW-1:0] r_ic;
    logic [RW-1:0] r_orow;
    logic [CW-1:0] r_ocol;
    logic at_out, shrunk, is_last, restart, has_res;

    always_comb begin
        at_out  = r_run || (r_cnt >= delay);
        shrunk  = (HW'(r_orow) >= h_c) || (WW'(r_ocol) >= w_c);
        is_last = (HW'(r_orow) + HW'(1) == h_c) && (WW'(r_ocol) + WW'(1) == w_c);
        has_res = at_out && !shrunk;
        restart = at_out && (shrunk || is_last);
    end

    // Advance input column, output position and warm-up count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_run  <= 1'b0;
            r_ic   <= '0;
            r_orow <= '0;
            r_ocol <= '0;
        end else if (pix_acc) begin
            if (restart) begin
                r_cnt  <= '0;
                r_run  <= 1'b0;
                r_ic   <= '0;
                r_orow <= '0;
                r_ocol <= '0;
            end else begin
                if (WW'(r_ic) + WW'(1) >= w_c) r_ic <= '0;
                else                           r_ic <= r_ic + 1'b1;
                if (!at_out) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_run <= 1'b1;
                    if (WW'(r_ocol) + WW'(1) >= w_c) begin
                        r_ocol <= '0;
                        r_orow <= r_orow + 1'b1;
                    end else begin
                        r_ocol <= r_ocol + 1'b1;
                    end
                end
            end
        end
    end

    // Window mask: drop taps outside the image or the kernel
    logic [MK*MK-1:0] mask;

    always_comb begin
        int ri;
        int ci;
        mask = '0;
        for (int m = 0; m < MK; m++) begin
            for (int n = 0; n < MK; n++) begin
                ri = int'(r_orow) + int'(cy) - m;
                ci = int'(r_ocol) + int'(cx) - n;
                mask[m*MK+n] = (m < int'(kh_c)) && (n < int'(kw_c)) &&
                               (ri >= 0) && (ri < int'(h_c)) &&
                               (ci >= 0) && (ci < int'(w_c));
            end
        end
    end

    // ---------------- stage 1: line memories and window ----------------
    logic             r_res1, r_last1, r_fwd1;
    logic [MK*MK-1:0] r_mask1;
    logic [PXW-1:0]   r_samp1;
    logic [CW-1:0]    r_addr1;
    logic [PXW-1:0]   rd   [MK];
    logic [PXW-1:0]   colv [MK];
    logic [PXW-1:0]   r_pcol [MK];
    logic [PXW-1:0]   r_win  [MK][MK];
    logic [PXW-1:0]   win_now [MK][MK];
    logic             wr_en;

    assign wr_en = r_v1 && adv1;
    assign rd[0] = '0;

    // Load stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= pix_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_res1  <= has_res;
            r_last1 <= is_last;
            r_mask1 <= mask;
            r_samp1 <= (op == c2dz_pkg::OP_PIXEL) ? s_tdata[7:0] : '0;
            r_addr1 <= r_ic;
            r_fwd1  <= r_v1 && (r_addr1 == r_ic);
        end
    end

    // One line memory per row of delay
    for (genvar j = 1; j < MK; j++) begin : g_line
        c2dz_ram #(
            .WIDTH(PXW),
            .DEPTH(MAX_WIDTH)
        ) u_line (
            .i_clk  (i_clk),
            .i_we   (wr_en),
            .i_waddr(r_addr1),
            .i_wdata(colv[j-1]),
            .i_re   (pix_acc),
            .i_raddr(r_ic),
            .o_rdata(rd[j])
        );
    end

    // Build the column; forward the write that collided with this read
    always_comb begin
        colv[0] = r_samp1;
        for (int j = 1; j < MK; j++) begin
            colv[j] = r_fwd1 ? r_pcol[j-1] : rd[j];
        end
        for (int m = 0; m < MK; m++) begin
            win_now[m][0] = colv[m];
            for (int n = 1; n < MK; n++) begin
                win_now[m][n] = r_win[m][n-1];
            end
        end
    end

    // Shift the window and hold the last written column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MK; m++) begin
                for (int n = 0; n < MK; n++) begin
                    r_win[m][n] <= '0;
                end
            end
        end else if (wr_en) begin
            r_win <= win_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pcol <= colv;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [PW-1:0] r_prod [MK][MK];
    logic signed [PW-1:0] p_now  [MK][MK];
    logic                 r_last2;

    always_comb begin
        for (int m = 0; m < MK; m++) begin
            for (int n = 0; n < MK; n++) begin
                if (r_mask1[m*MK+n]) p_now[m][n] = $signed({1'b0, win_now[m][n]}) * r_coef[m][n];
                else                 p_now[m][n] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1 && r_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_prod  <= p_now;
            r_last2 <= r_last1;
        end
    end

    // ---------------- stage 3: row sums ----------------
    logic signed [SW-1:0] r_rsum [MK];
    logic signed [SW-1:0] rs_now [MK];
    logic                 r_last3;

    always_comb begin
        for (int m = 0; m < MK; m++) begin
            rs_now[m] = '0;
            for (int n = 0; n < MK; n++) begin
                rs_now[m] = rs_now[m] + SW'(r_prod[m][n]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_v2) begin
            r_rsum  <= rs_now;
            r_last3 <= r_last2;
        end
    end

    // ---------------- output register: total ----------------
    logic signed [SW-1:0]    total;
    logic [c2dz_pkg::OUT_W-1:0] r_odata;
    logic                    r_olast;

    always_comb begin
        total = '0;
        for (int m = 0; m < MK; m++) begin
            total = total + r_rsum[m];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv_o) begin
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o && r_v3) begin
            r_odata <= c2dz_pkg::OUT_W'(total);
            r_olast <= r_last3;
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = 32'(r_odata);
    assign m_tlast  = r_olast;

`ifndef SYNTH
    // Every accepted pixel or drain beat lands in stage 1
    a_pix_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc |=> r_v1)
        else $error("pixel beat lost before stage 1");

    // A product set only starts from a result-bearing stage 1 item
    a_s2_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v2) |-> $past(r_v1 && r_res1))
        else $error("stage 2 loaded without a source item");

    // Forwarding needs a writer in stage 1 the cycle before
    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_fwd1) |-> $past(r_v1))
        else $error("forward flagged without a preceding write");
`endif

endmodule

`default_nettype wire

// ----- design/c2dz_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module c2dz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
